FILE: sv/utf8dct_pkg.sv
// ----------------------------------------------------------------------------
// utf8dct_pkg
// Types and constants for the UTF-8 decoder with cell column tracking.
// ----------------------------------------------------------------------------
package utf8dct_pkg;

  // Width of the internal column counter. The column saturates at its maximum.
  localparam int COLUMN_BITS = 8;
  localparam int CP_BITS     = 21;

  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

  localparam logic [7:0] LEAD2_MASK = 8'b0001_1111;
  localparam logic [7:0] LEAD3_MASK = 8'b0000_1111;
  localparam logic [7:0] LEAD4_MASK = 8'b0000_0111;
  localparam logic [7:0] CONT_MASK  = 8'b0011_1111;
  localparam logic [7:0] ASCII_MAX  = 8'h7f;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_BAD_LEAD = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       string_start;
  } in_word_t;

  typedef struct packed {
    logic [CP_BITS-1:0] code_point;
    logic [7:0]         cell_column;
    logic               wide_char;
    logic               decode_status;
  } out_word_t;

  typedef struct packed {
    logic [1:0]             bytes_remaining;
    logic [CP_BITS-1:0]     code_accumulator;
    logic [COLUMN_BITS-1:0] column_count;
  } dec_state_t;

endpackage

FILE: sv/utf8dct_decode.sv
// ----------------------------------------------------------------------------
// utf8dct_decode
// Decode step for one byte: next decoder state and the optional result word.
// ----------------------------------------------------------------------------
module utf8dct_decode (
  input  utf8dct_pkg::dec_state_t state,
  input  utf8dct_pkg::in_word_t   in_word,
  output utf8dct_pkg::dec_state_t state_next,
  output logic                    res_valid,
  output utf8dct_pkg::out_word_t  res_word
);
  import utf8dct_pkg::*;

  logic [1:0]             rem_cur;
  logic [CP_BITS-1:0]     acc_cur;
  logic [COLUMN_BITS-1:0] col_cur;
  logic [CP_BITS-1:0]     acc_shift;
  logic [1:0]             rem_dec;
  logic [7:0]             b;
  logic                   emit_ok;
  logic [CP_BITS-1:0]     emit_cp;
  logic                   wide;
  logic [COLUMN_BITS:0]   col_sum;
  logic [COLUMN_BITS+7:0] col_ext;

  always_comb begin
    b       = in_word.text_byte;
    rem_cur = in_word.string_start ? 2'd0 : state.bytes_remaining;
    acc_cur = in_word.string_start ? '0 : state.code_accumulator;
    col_cur = in_word.string_start ? '0 : state.column_count;

    acc_shift = {acc_cur[CP_BITS-7:0], b[5:0] & CONT_MASK[5:0]};
    rem_dec   = rem_cur - 2'd1;

    state_next                  = state;
    state_next.bytes_remaining  = rem_cur;
    state_next.code_accumulator = acc_cur;
    state_next.column_count     = col_cur;
    res_valid = 1'b0;
    emit_ok   = 1'b0;
    emit_cp   = '0;

    if (rem_cur != 2'd0) begin
      // Any byte inside a sequence counts as a continuation byte.
      state_next.bytes_remaining = rem_dec;
      if (rem_dec == 2'd0) begin
        state_next.code_accumulator = '0;
        res_valid = 1'b1;
        emit_ok   = 1'b1;
        emit_cp   = acc_shift;
      end else begin
        state_next.code_accumulator = acc_shift;
      end
    end else begin
      case (b) inside
        [8'h00:8'h7f]: begin
          res_valid = 1'b1;
          emit_ok   = 1'b1;
          emit_cp   = {{(CP_BITS-8){1'b0}}, b};
        end
        [8'hc0:8'hdf]: begin
          state_next.code_accumulator = {{(CP_BITS-8){1'b0}}, b & LEAD2_MASK};
          state_next.bytes_remaining  = 2'd1;
        end
        [8'he0:8'hef]: begin
          state_next.code_accumulator = {{(CP_BITS-8){1'b0}}, b & LEAD3_MASK};
          state_next.bytes_remaining  = 2'd2;
        end
        [8'hf0:8'hf7]: begin
          state_next.code_accumulator = {{(CP_BITS-8){1'b0}}, b & LEAD4_MASK};
          state_next.bytes_remaining  = 2'd3;
        end
        default: begin
          // Stray continuation byte or invalid lead: error word, no advance.
          state_next.code_accumulator = '0;
          res_valid = 1'b1;
        end
      endcase
    end

    wide    = emit_ok && (emit_cp > {{(CP_BITS-8){1'b0}}, ASCII_MAX});
    col_sum = {1'b0, col_cur} + (wide ? (COLUMN_BITS+1)'(2) : (COLUMN_BITS+1)'(1));
    if (emit_ok) begin
      state_next.column_count = (col_sum > {1'b0, COL_MAX}) ? COL_MAX
                                                             : col_sum[COLUMN_BITS-1:0];
    end

    col_ext                = {8'b0, col_cur};
    res_word.code_point    = emit_cp;
    res_word.cell_column   = col_ext[7:0];
    res_word.wide_char     = wide;
    res_word.decode_status = emit_ok ? STATUS_OK : STATUS_BAD_LEAD;
  end

endmodule

FILE: sv/utf8_decode_column_track_core.sv
// ----------------------------------------------------------------------------
// utf8_decode_column_track_core
// UTF-8 byte stream decoder that reports each character's cell column.
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_ready  in_data  (text_byte, string_start)
//   out      output     out_valid/ out_ready out_data (code_point, cell_column,
//                                                      wide_char, decode_status)
//
// One byte is accepted per cycle while the output register is not stalled. An
// accepted byte is held in the input register, is decoded against the state
// registers and its result lands in the output register when that register
// has room.
// Synchronous reset clears the valid flags and the decoder state.
// A stalled output register holds the input stage, which then drops in_ready.
// ----------------------------------------------------------------------------
module utf8_decode_column_track_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  utf8dct_pkg::in_word_t  in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output utf8dct_pkg::out_word_t out_data
);
  import utf8dct_pkg::*;

  logic       in_full;
  in_word_t   in_reg;
  dec_state_t state;
  dec_state_t state_next;
  logic       res_valid;
  out_word_t  res_word;
  logic       advance;

  // The input stage moves on only when the output register has room.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  utf8dct_decode u_decode (
    .state      (state),
    .in_word    (in_reg),
    .state_next (state_next),
    .res_valid  (res_valid),
    .res_word   (res_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
      state     <= '0;
    end else begin
      if (in_ready) begin
        in_full <= in_valid;
      end
      if (advance) begin
        state <= state_next;
      end
      if (advance) begin
        out_valid <= res_valid;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (advance && res_valid) begin
      out_data <= res_word;
    end
  end

endmodule

FILE: tb/sv/utf8_decode_column_track_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_decode_column_track_core_test
// Self-checking testbench for the UTF-8 decoder with cell column tracking.
//
// A short directed byte list covers the field extremes, every sequence length,
// bad lead bytes, lead-like continuations, string restarts and overlong forms.
// Random strings of well-formed characters with noise and truncated sequences
// follow, and a few long strings drive the column into saturation. A predictor
// keeps its own decoder state and queues the expected word for each character
// or bad lead byte; the monitor checks each output word against the oldest entry.
// Both sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module utf8_decode_column_track_core_test;
  import utf8dct_pkg::*;

  localparam int DIRECTED_BYTES = 26;
  localparam int RANDOM_BYTES   = 1800;
  localparam int HOLD_AT        = 600;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int RUN_LIMIT      = 1000000;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  utf8_decode_column_track_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  in_word_t  pending_bytes[$];
  out_word_t expected_chars[$];

  // Predictor state.
  logic [1:0]             cont_left = '0;
  logic [CP_BITS-1:0]     code_acc  = '0;
  logic [COLUMN_BITS-1:0] col_count = '0;

  logic        in_fire  = 1'b0;
  logic        out_fire = 1'b0;
  int          in_count = 0;
  int          queued_bytes = 0;
  int          error_count = 0;
  int          n_chars = 0;
  int          n_wide = 0;
  int          n_bad_lead = 0;
  int          n_saturated = 0;
  int          n_starts = 0;
  int          in_gap = 0;
  int          in_calm = 0;
  int          rx_gap = 0;
  int          rx_calm = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_count = 0;

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int draw_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(30, 120);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic s);
    in_word_t w;
    w.text_byte    = b;
    w.string_start = s;
    pending_bytes.push_back(w);
    queued_bytes++;
  endtask

  // A lead byte for a sequence of the given length with random payload, then
  // the given number of trailing bytes, mostly continuations (fewer than needed makes it truncated).
  task automatic push_seq(input int len, input int conts, input logic s);
    logic [7:0] lead;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    push_byte(lead, s);
    repeat (conts) begin
      push_byte(($urandom_range(0, 9) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)}, 1'b0);
    end
  endtask

  task automatic emit_char(input logic [CP_BITS-1:0] cp, input logic status);
    out_word_t w;
    int        step;
    w.code_point    = cp;
    w.cell_column   = 8'(col_count);
    w.wide_char     = (status == STATUS_OK) && (cp > CP_BITS'(ASCII_MAX));
    w.decode_status = status;
    expected_chars.push_back(w);
    if (status == STATUS_BAD_LEAD) n_bad_lead++;
    else n_chars++;
    if (w.wide_char) n_wide++;
    if (col_count == COL_MAX) n_saturated++;
    if (status == STATUS_OK) begin
      step = w.wide_char ? 2 : 1;
      if (int'(col_count) + step > int'(COL_MAX)) col_count = COL_MAX;
      else col_count = col_count + COLUMN_BITS'(step);
    end
  endtask

  task automatic decode_byte(input in_word_t w);
    logic [7:0] b;
    b = w.text_byte;
    if (w.string_start) begin
      col_count = '0;
      cont_left = '0;
      code_acc  = '0;
      n_starts++;
    end
    // While continuations are due, any byte is taken as one.
    if (cont_left != 0) begin
      code_acc  = (code_acc << 6) | CP_BITS'(b & CONT_MASK);
      cont_left = cont_left - 2'd1;
      if (cont_left == 0) begin
        emit_char(code_acc, STATUS_OK);
        code_acc = '0;
      end
    end else if (b <= ASCII_MAX) begin
      emit_char(CP_BITS'(b), STATUS_OK);
    end else if (b[7:5] == 3'b110) begin
      code_acc  = CP_BITS'(b & LEAD2_MASK);
      cont_left = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      code_acc  = CP_BITS'(b & LEAD3_MASK);
      cont_left = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      code_acc  = CP_BITS'(b & LEAD4_MASK);
      cont_left = 2'd3;
    end else begin
      code_acc = '0;
      emit_char('0, STATUS_BAD_LEAD);
    end
  endtask

  // Sampling at the rising edge: predict on every accepted byte, check every
  // accepted output word.
  always @(posedge clk) begin
    out_word_t want;
    cycle_count <= cycle_count + 1;
    in_fire     <= !rst && in_valid && in_ready;
    out_fire    <= !rst && out_valid && out_ready;
    if (!rst && in_valid && in_ready) begin
      decode_byte(in_data);
      in_count++;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count < 20)
          $display("%0t: unexpected word: expected none, actual cp=%h col=%0d wide=%b st=%b",
                   $time, out_data.code_point, out_data.cell_column, out_data.wide_char,
                   out_data.decode_status);
      end else begin
        want = expected_chars.pop_front();
        if (out_data !== want) begin
          error_count++;
          if (error_count < 20)
            $display("%0t: mismatch: expected cp=%h col=%0d wide=%b st=%b, actual cp=%h col=%0d wide=%b st=%b",
                     $time, want.code_point, want.cell_column, want.wide_char,
                     want.decode_status, out_data.code_point, out_data.cell_column,
                     out_data.wide_char, out_data.decode_status);
        end
      end
    end
  end

  // Sender: a word stays on the bus until the edge that accepts it.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // Still waiting for acceptance.
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (pending_bytes.size() != 0) begin
      in_data  <= pending_bytes.pop_front();
      in_valid <= 1'b1;
      in_gap   = draw_gap(in_calm);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls after each word, plus one long hold-off while the
  // sender keeps offering bytes.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && in_count >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (out_fire) rx_gap = draw_gap(rx_calm);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", cycle_count);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int  nchars;
    int  r;
    int  len;
    bit  first_string;
    logic s;

    // Directed bytes.
    push_byte(8'h41, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7f, 1'b0);
    push_byte(8'hc3, 1'b0); push_byte(8'ha9, 1'b0);
    push_byte(8'he2, 1'b0); push_byte(8'h82, 1'b0); push_byte(8'hac, 1'b0);
    push_byte(8'hf0, 1'b0); push_byte(8'h9f, 1'b0); push_byte(8'h98, 1'b0);
    push_byte(8'h80, 1'b0);
    // Largest value a four-byte form can carry.
    push_byte(8'hf7, 1'b0); push_byte(8'hbf, 1'b0); push_byte(8'hbf, 1'b0);
    push_byte(8'hbf, 1'b0);
    // Bad lead bytes at both ends of each invalid range.
    push_byte(8'h80, 1'b0);
    push_byte(8'hbf, 1'b0);
    push_byte(8'hf8, 1'b0);
    push_byte(8'hff, 1'b0);
    // A lead-like byte in continuation position counts as a continuation.
    push_byte(8'hc3, 1'b0); push_byte(8'he2, 1'b0);
    // A string start drops the partial sequence.
    push_byte(8'he2, 1'b0); push_byte(8'h41, 1'b1);
    // Overlong form decodes without checks.
    push_byte(8'hc0, 1'b0); push_byte(8'h80, 1'b0);

    // Random strings; the first one is long enough to reach saturation.
    first_string = 1'b1;
    while (queued_bytes < DIRECTED_BYTES + RANDOM_BYTES) begin
      if (first_string) nchars = 200;
      else if ($urandom_range(0, 9) == 0) nchars = $urandom_range(150, 260);
      else nchars = $urandom_range(3, 40);
      first_string = 1'b0;
      for (int i = 0; i < nchars; i++) begin
        s = (i == 0);
        r = $urandom_range(0, 99);
        if (r < 40) begin
          push_seq(1, 0, s);
        end else if (r < 55) begin
          push_seq(2, 1, s);
        end else if (r < 70) begin
          push_seq(3, 2, s);
        end else if (r < 80) begin
          push_seq(4, 3, s);
        end else if (r < 90) begin
          push_byte(8'($urandom), s | ($urandom_range(0, 19) == 0));
        end else if (r < 95) begin
          len = $urandom_range(2, 4);
          push_seq(len, $urandom_range(0, len - 2), s);
        end else begin
          push_byte($urandom_range(0, 1) ? {2'b10, 6'($urandom)} : {5'b11111, 3'($urandom)}, s);
        end
      end
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) error_count++;

    $display("Covered %0d bytes in %0d strings: %0d characters (%0d wide), %0d bad lead bytes.",
             in_count, n_starts, n_chars, n_wide, n_bad_lead);
    $display("%0d words at the saturated column; one receiver hold-off of %0d cycles.",
             n_saturated, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/utf8dct_pkg.sv
sv/utf8dct_decode.sv
sv/utf8_decode_column_track_core.sv
tb/sv/utf8_decode_column_track_core_test.sv
